// ===== hw/rtl/vcf_gp_pkg.sv =====
// Shared types and constants for the variant record genotype parser.
package vcf_gp_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [12:0] FIELD_MAX = 13'd8191;
  localparam logic [12:0] FIRST_SAMPLE_FIELD = 13'd9;

  localparam logic [7:0] CH_NL = 8'd10;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_BAR = 8'h7c;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [1:0] KIND_CHROM = 2'd0;
  localparam logic [1:0] KIND_GENO = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_DONE_NOSEP = 2'd2;
  localparam logic [1:0] PH_DONE_SEP = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  chrom;
    logic [11:0] idx;
    logic [7:0]  a1;
    logic [7:0]  a2;
    logic [31:0] pos;
    logic        comp;
    logic [12:0] cnt;
    logic        last;
  } res_t;

endpackage

// ===== hw/rtl/vcf_record_genotype_parser.sv =====
// Variant record line parser: chromosome bytes, position and per-sample genotypes.
// Results of an accepted byte are written into the result queue and leave it on the out_ channel.
// Throughput: one byte per cycle while in_ready is high, i.e. while the 4-entry result
// queue holds at most two entries; a newline that closes a genotype yields two transactions.
// Reset (rst_n low, synchronous) clears the parse state and empties the queue.
module vcf_record_genotype_parser #(
  parameter int MAX_SAMPLES = vcf_gp_pkg::MAX_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_chrom_char,
  output logic [11:0] out_sample_index,
  output logic [7:0]  out_allele_first,
  output logic [7:0]  out_allele_second,
  output logic [31:0] out_position,
  output logic        out_record_complete,
  output logic [12:0] out_sample_count,
  output logic        out_last_of_run
);

  logic [12:0] field_r, field_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  second_r, second_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        stopped_r, stopped_nxt;
  logic        started_r, started_nxt;
  logic        skip_r, skip_nxt;

  vcf_gp_pkg::res_t q_r [vcf_gp_pkg::QDEPTH];
  logic [vcf_gp_pkg::QAW-1:0] wptr_r, rptr_r;
  logic [vcf_gp_pkg::QAW:0]   qcnt_r;

  vcf_gp_pkg::res_t r0, r1;
  logic [1:0]  nres;
  logic        in_acc, out_acc;

  logic [7:0]  c;
  logic        is_digit;
  logic [3:0]  dig;
  logic        field_ge9, geno;
  logic [12:0] gi;
  logic [13:0] gi_p1;
  logic [12:0] cnt_sat;
  logic [35:0] pos_mul;
  logic [31:0] pos_add;
  logic [7:0]  al_src;
  logic [11:0] al_mul;
  logic [7:0]  al_add;
  logic [7:0]  a2_sel;
  logic [12:0] field_inc;
  vcf_gp_pkg::res_t r_geno, r_end;

  assign in_ready  = qcnt_r <= (vcf_gp_pkg::QAW+1)'(vcf_gp_pkg::QDEPTH - 2);
  assign out_valid = qcnt_r != '0;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  assign c         = in_char_in;
  assign is_digit  = (c >= vcf_gp_pkg::CH_ZERO) && (c <= vcf_gp_pkg::CH_NINE);
  assign dig       = 4'(c - vcf_gp_pkg::CH_ZERO);
  assign field_ge9 = field_r >= vcf_gp_pkg::FIRST_SAMPLE_FIELD;
  assign gi        = field_ge9 ? field_r - vcf_gp_pkg::FIRST_SAMPLE_FIELD : '0;
  assign geno      = field_ge9 && (32'(gi) < 32'(MAX_SAMPLES));
  assign gi_p1     = 14'(gi) + 14'd1;
  assign cnt_sat   = (32'(gi_p1) > 32'(MAX_SAMPLES)) ? 13'(MAX_SAMPLES) : gi_p1[12:0];
  assign field_inc = (field_r == vcf_gp_pkg::FIELD_MAX) ? field_r : field_r + 13'd1;

  assign pos_mul = ({4'b0, pos_r} << 3) + ({4'b0, pos_r} << 1) + 36'(dig);
  assign pos_add = (pos_mul[35:32] != 4'd0) ? 32'hffff_ffff : pos_mul[31:0];

  assign al_src = (phase_r == vcf_gp_pkg::PH_FIRST) ? first_r : second_r;
  assign al_mul = ({4'b0, al_src} << 3) + ({4'b0, al_src} << 1) + 12'(dig);
  assign al_add = (al_mul > 12'd255) ? 8'd255 : al_mul[7:0];

  assign a2_sel = (phase_r == vcf_gp_pkg::PH_SECOND || phase_r == vcf_gp_pkg::PH_DONE_SEP)
                  ? second_r : first_r;

  always_comb begin
    r_geno       = '0;
    r_geno.kind  = vcf_gp_pkg::KIND_GENO;
    r_geno.idx   = gi[11:0];
    r_geno.a1    = first_r;
    r_geno.a2    = a2_sel;
    r_geno.cnt   = gi_p1[12:0];
    r_end        = '0;
    r_end.kind   = vcf_gp_pkg::KIND_END;
    r_end.pos    = pos_r;
  end

  always_comb begin
    field_nxt   = field_r;
    pos_nxt     = pos_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    phase_nxt   = phase_r;
    stopped_nxt = stopped_r;
    started_nxt = started_r;
    skip_nxt    = skip_r;
    r0          = '0;
    r1          = '0;
    nres        = 2'd0;

    if (skip_r) begin
      if (c == vcf_gp_pkg::CH_NL) begin
        field_nxt   = '0;
        pos_nxt     = '0;
        first_nxt   = '0;
        second_nxt  = '0;
        phase_nxt   = vcf_gp_pkg::PH_FIRST;
        stopped_nxt = 1'b0;
        started_nxt = 1'b0;
        skip_nxt    = 1'b0;
      end
    end else if (c == vcf_gp_pkg::CH_NL) begin
      nres = 2'd1;
      r0   = r_end;
      if (!field_ge9) begin
        r0.comp = 1'b0;
      end else if (geno && !started_r) begin
        r0.cnt = gi;
      end else if (geno) begin
        nres     = 2'd2;
        r0       = r_geno;
        r1       = r_end;
        r1.comp  = 1'b1;
        r1.cnt   = cnt_sat;
        r1.last  = 1'b1;
      end else begin
        r0.comp = 1'b1;
        r0.cnt  = cnt_sat;
      end
      if (nres == 2'd1) r0.last = 1'b1;
      field_nxt   = '0;
      pos_nxt     = '0;
      first_nxt   = '0;
      second_nxt  = '0;
      phase_nxt   = vcf_gp_pkg::PH_FIRST;
      stopped_nxt = 1'b0;
      started_nxt = 1'b0;
      skip_nxt    = 1'b0;
    end else if (c == vcf_gp_pkg::CH_TAB) begin
      if (geno && !started_r) begin
        nres     = 2'd1;
        r0       = r_end;
        r0.cnt   = gi;
        r0.last  = 1'b1;
        skip_nxt = 1'b1;
      end else begin
        if (geno) begin
          nres    = 2'd1;
          r0      = r_geno;
          r0.last = 1'b1;
        end
        field_nxt   = field_inc;
        first_nxt   = '0;
        second_nxt  = '0;
        phase_nxt   = vcf_gp_pkg::PH_FIRST;
        stopped_nxt = 1'b0;
        started_nxt = 1'b0;
      end
    end else if (field_r == 13'd0) begin
      nres     = 2'd1;
      r0.kind  = vcf_gp_pkg::KIND_CHROM;
      r0.chrom = c;
      r0.last  = 1'b1;
    end else if (field_r == 13'd1) begin
      if (is_digit && !stopped_r) pos_nxt = pos_add;
      else stopped_nxt = 1'b1;
    end else if (geno) begin
      if (!started_r && c == vcf_gp_pkg::CH_DOT) begin
        started_nxt = 1'b1;
        nres        = 2'd1;
        r0          = r_end;
        r0.cnt      = gi;
        r0.last     = 1'b1;
        skip_nxt    = 1'b1;
      end else begin
        started_nxt = 1'b1;
        if (phase_r == vcf_gp_pkg::PH_FIRST || phase_r == vcf_gp_pkg::PH_SECOND) begin
          if (c == vcf_gp_pkg::CH_COLON) begin
            phase_nxt = (phase_r == vcf_gp_pkg::PH_FIRST) ? vcf_gp_pkg::PH_DONE_NOSEP
                                                          : vcf_gp_pkg::PH_DONE_SEP;
          end else if ((c == vcf_gp_pkg::CH_SLASH || c == vcf_gp_pkg::CH_BAR) &&
                       phase_r == vcf_gp_pkg::PH_FIRST) begin
            phase_nxt   = vcf_gp_pkg::PH_SECOND;
            stopped_nxt = 1'b0;
          end else if (is_digit && !stopped_r) begin
            if (phase_r == vcf_gp_pkg::PH_FIRST) first_nxt = al_add;
            else second_nxt = al_add;
          end else begin
            stopped_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r   <= '0;
      pos_r     <= '0;
      first_r   <= '0;
      second_r  <= '0;
      phase_r   <= vcf_gp_pkg::PH_FIRST;
      stopped_r <= 1'b0;
      started_r <= 1'b0;
      skip_r    <= 1'b0;
    end else if (in_acc) begin
      field_r   <= field_nxt;
      pos_r     <= pos_nxt;
      first_r   <= first_nxt;
      second_r  <= second_nxt;
      phase_r   <= phase_nxt;
      stopped_r <= stopped_nxt;
      started_r <= started_nxt;
      skip_r    <= skip_nxt;
    end
  end

  // result queue
  logic [1:0] push_n;
  assign push_n = in_acc ? nres : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      qcnt_r <= '0;
    end else begin
      wptr_r <= wptr_r + vcf_gp_pkg::QAW'(push_n);
      if (out_acc) rptr_r <= rptr_r + vcf_gp_pkg::QAW'(1);
      qcnt_r <= qcnt_r + (vcf_gp_pkg::QAW+1)'(push_n) -
                (vcf_gp_pkg::QAW+1)'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wptr_r] <= r0;
    if (push_n == 2'd2) q_r[wptr_r + vcf_gp_pkg::QAW'(1)] <= r1;
  end

  assign out_result_kind     = q_r[rptr_r].kind;
  assign out_chrom_char      = q_r[rptr_r].chrom;
  assign out_sample_index    = q_r[rptr_r].idx;
  assign out_allele_first    = q_r[rptr_r].a1;
  assign out_allele_second   = q_r[rptr_r].a2;
  assign out_position        = q_r[rptr_r].pos;
  assign out_record_complete = q_r[rptr_r].comp;
  assign out_sample_count    = q_r[rptr_r].cnt;
  assign out_last_of_run     = q_r[rptr_r].last;

endmodule
